/* rtl/ssen_pkg.sv */
// Shared types and constants of the sorted set engine.
// No dependencies; the interfaces, the core and the testbench refer to it by scoped names.
package ssen_pkg;

  localparam int CMD_W    = 2;
  localparam int KEY_W    = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_DECIDE,
    S_UP,
    S_PUT,
    S_DN,
    S_DONE
  } state_t;

endpackage

/* rtl/ssen_if.sv */
// Request and response channels of the sorted set engine.
// Depends on ssen_pkg for the payload widths.
interface ssen_req_if;
  logic                            valid;
  logic                            ready;
  logic [ssen_pkg::CMD_W-1:0]      command;
  logic signed [ssen_pkg::KEY_W-1:0] key;

  modport source (output valid, command, key, input ready);
  modport sink (input valid, command, key, output ready);
endinterface

interface ssen_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ssen_pkg::STATUS_W-1:0] status;
  logic [ssen_pkg::COUNT_W-1:0]  count;

  modport source (output valid, status, count, input ready);
  modport sink (input valid, status, count, output ready);
endinterface

/* rtl/sorted_set_engine_core.sv */
// Sorted set engine: keeps distinct signed keys in ascending order in one memory.
// Clear goes straight to the response; other commands first scan the stored keys to the key's
// position, then remove and insert shift the entries behind it and insert stores the key.
// One request at a time; the next is taken once the response has been loaded.
// Reset clears the count and control state; memory contents need no clearing pass.
// Depends on ssen_pkg, ssen_if and ssen_ram.
module sorted_set_engine_core #(
  parameter int CAPACITY = 64
) (
  input  logic           clk,
  input  logic           rst,
  ssen_req_if.sink       req,
  ssen_rsp_if.source     rsp
);

  localparam int AW = $clog2(CAPACITY);
  localparam int PW = $clog2(CAPACITY + 1);

  ssen_pkg::state_t state, state_next;

  logic [ssen_pkg::CMD_W-1:0]      cmd;
  logic [ssen_pkg::KEY_W-1:0]      key;
  logic [PW-1:0]                   ptr, ptr_next;
  logic [PW-1:0]                   cur, cur_next;
  logic [PW-1:0]                   held, held_next;
  logic                            hit, hit_next;
  logic [ssen_pkg::STATUS_W-1:0]   res, res_next;

  logic                            ram_we;
  logic [PW-1:0]                   waddr_p, raddr_p;
  logic [ssen_pkg::KEY_W-1:0]      ram_wdata, ram_rdata;

  logic accept, out_load, key_lt, full;
  logic [PW-1:0] ptr_inc;

  assign accept   = req.valid && req.ready;
  assign out_load = (state == ssen_pkg::S_DONE) && (!rsp.valid || rsp.ready);
  assign key_lt   = $signed(ram_rdata) < $signed(key);
  assign full     = held == PW'(CAPACITY);
  assign ptr_inc  = ptr + PW'(1);
  assign req.ready = state == ssen_pkg::S_IDLE;

  ssen_ram #(
    .DEPTH(CAPACITY),
    .WIDTH(ssen_pkg::KEY_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr_p[AW-1:0]),
    .wdata (ram_wdata),
    .raddr (raddr_p[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ssen_pkg::S_IDLE: begin
        if (accept) begin
          if (req.command == ssen_pkg::CMD_CLEAR) begin
            state_next = ssen_pkg::S_DONE;
          end else if (held == '0) begin
            state_next = ssen_pkg::S_DECIDE;
          end else begin
            state_next = ssen_pkg::S_READ;
          end
        end
      end
      ssen_pkg::S_READ: state_next = ssen_pkg::S_CMP;
      ssen_pkg::S_CMP: begin
        if (!key_lt || ptr_inc == held) begin
          state_next = ssen_pkg::S_DECIDE;
        end
      end
      ssen_pkg::S_DECIDE: begin
        priority if (cmd == ssen_pkg::CMD_INSERT) begin
          if (hit || full) begin
            state_next = ssen_pkg::S_DONE;
          end else if (held == ptr) begin
            state_next = ssen_pkg::S_PUT;
          end else begin
            state_next = ssen_pkg::S_UP;
          end
        end else if (cmd == ssen_pkg::CMD_REMOVE) begin
          if (!hit || ptr_inc == held) begin
            state_next = ssen_pkg::S_DONE;
          end else begin
            state_next = ssen_pkg::S_DN;
          end
        end else begin
          state_next = ssen_pkg::S_DONE;
        end
      end
      ssen_pkg::S_UP: begin
        if (cur - PW'(1) == ptr) begin
          state_next = ssen_pkg::S_PUT;
        end
      end
      ssen_pkg::S_PUT: state_next = ssen_pkg::S_DONE;
      ssen_pkg::S_DN: begin
        if (cur + PW'(2) == held) begin
          state_next = ssen_pkg::S_DONE;
        end
      end
      ssen_pkg::S_DONE: begin
        if (out_load) begin
          state_next = ssen_pkg::S_IDLE;
        end
      end
      default: state_next = ssen_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ptr_next  = ptr;
    cur_next  = cur;
    held_next = held;
    hit_next  = hit;
    res_next  = res;
    ram_we    = 1'b0;
    waddr_p   = cur;
    ram_wdata = ram_rdata;
    raddr_p   = ptr;
    unique case (state)
      ssen_pkg::S_IDLE: begin
        ptr_next = '0;
        hit_next = 1'b0;
        res_next = ssen_pkg::ST_OK;
        if (accept && req.command == ssen_pkg::CMD_CLEAR) begin
          held_next = '0;
        end
      end
      ssen_pkg::S_READ: raddr_p = ptr;
      ssen_pkg::S_CMP: begin
        raddr_p = ptr_inc;
        if (key_lt) begin
          ptr_next = ptr_inc;
        end else begin
          hit_next = ram_rdata == key;
        end
      end
      ssen_pkg::S_DECIDE: begin
        priority if (cmd == ssen_pkg::CMD_INSERT) begin
          raddr_p  = held - PW'(1);
          cur_next = held;
          if (hit) begin
            res_next = ssen_pkg::ST_MISS;
          end else if (full) begin
            res_next = ssen_pkg::ST_FULL;
          end
        end else if (cmd == ssen_pkg::CMD_REMOVE) begin
          raddr_p  = ptr_inc;
          cur_next = ptr;
          if (!hit) begin
            res_next = ssen_pkg::ST_MISS;
          end else if (ptr_inc == held) begin
            held_next = held - PW'(1);
          end
        end else begin
          res_next = hit ? ssen_pkg::ST_OK : ssen_pkg::ST_MISS;
        end
      end
      ssen_pkg::S_UP: begin
        ram_we   = 1'b1;
        waddr_p  = cur;
        cur_next = cur - PW'(1);
        raddr_p  = cur - PW'(2);
      end
      ssen_pkg::S_PUT: begin
        ram_we    = 1'b1;
        waddr_p   = ptr;
        ram_wdata = key;
        held_next = held + PW'(1);
      end
      ssen_pkg::S_DN: begin
        ram_we   = 1'b1;
        waddr_p  = cur;
        cur_next = cur + PW'(1);
        raddr_p  = cur + PW'(2);
        if (cur + PW'(2) == held) begin
          held_next = held - PW'(1);
        end
      end
      ssen_pkg::S_DONE: raddr_p = ptr;
      default: raddr_p = ptr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ssen_pkg::S_IDLE;
      held      <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      held  <= held_next;
      if (out_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr <= ptr_next;
    cur <= cur_next;
    hit <= hit_next;
    res <= res_next;
    if (accept) begin
      cmd <= req.command;
      key <= req.key;
    end
    if (out_load) begin
      rsp.status <= res;
      rsp.count  <= ssen_pkg::COUNT_W'(held);
    end
  end

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= PW'(CAPACITY))
    else $error("held count exceeds capacity");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ssen_pkg::S_UP || state == ssen_pkg::S_PUT ||
                state == ssen_pkg::S_DN))
    else $error("memory written outside a shift or store step");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != ssen_pkg::S_IDLE)
    else $error("request accepted without starting work");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state) == ssen_pkg::S_DONE)
    else $error("response raised outside the finishing step");

  a_one_insert_step: assert property (@(posedge clk) disable iff (rst)
    state == ssen_pkg::S_PUT |=> held == $past(held) + PW'(1))
    else $error("insert did not grow the set by one");

endmodule

/* rtl/ssen_ram.sv */
// Single-write, single-read synchronous memory with registered read data.
// No dependencies.
module ssen_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* tb/sorted_set_engine_core_tb.sv */
`timescale 1ns / 100ps
// Testbench of sorted_set_engine_core: directed and random requests are checked against a
// queue-based model of the sorted set, one expected response per accepted request.
// Depends on ssen_pkg, ssen_if and the core itself.

typedef struct packed {
  logic [ssen_pkg::STATUS_W-1:0] status;
  logic [ssen_pkg::COUNT_W-1:0]  count;
} set_response_t;

class sorted_set_tracker #(int CAPACITY = 64);
  logic signed [ssen_pkg::KEY_W-1:0] members[$];
  set_response_t                     awaited[$];
  int unsigned                       failures;

  function new();
    failures = 0;
  endfunction

  function void note_request(logic [ssen_pkg::CMD_W-1:0] command,
                             logic signed [ssen_pkg::KEY_W-1:0] key);
    int            pos;
    bit            hit;
    set_response_t r;
    r.status = ssen_pkg::ST_OK;
    if (command == ssen_pkg::CMD_CLEAR) begin
      members.delete();
    end else begin
      pos = 0;
      while (pos < members.size() && members[pos] < key) pos++;
      hit = (pos < members.size()) && (members[pos] == key);
      unique case (command)
        ssen_pkg::CMD_INSERT: begin
          if (hit) r.status = ssen_pkg::ST_MISS;
          else if (members.size() >= CAPACITY) r.status = ssen_pkg::ST_FULL;
          else members.insert(pos, key);
        end
        ssen_pkg::CMD_REMOVE: begin
          if (!hit) r.status = ssen_pkg::ST_MISS;
          else members.delete(pos);
        end
        default: begin
          r.status = hit ? ssen_pkg::ST_OK : ssen_pkg::ST_MISS;
        end
      endcase
    end
    r.count = ssen_pkg::COUNT_W'(members.size());
    awaited.push_back(r);
  endfunction

  function void check_response(logic [ssen_pkg::STATUS_W-1:0] status,
                               logic [ssen_pkg::COUNT_W-1:0] count);
    set_response_t want;
    if (awaited.size() == 0) begin
      $error("Unexpected response: status %0d, count %0d.", status, count);
      failures++;
      return;
    end
    want = awaited.pop_front();
    if (status !== want.status) begin
      $error("Field status: expected %0d, actual %0d.", want.status, status);
      failures++;
    end
    if (count !== want.count) begin
      $error("Field count: expected %0d, actual %0d.", want.count, count);
      failures++;
    end
  endfunction

  function logic signed [ssen_pkg::KEY_W-1:0] pick_member();
    return members[$urandom_range(0, members.size() - 1)];
  endfunction
endclass

module sorted_set_engine_core_tb;
  localparam int CAPACITY     = 64;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 225;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int TAIL_CYCLES  = 2 * CAPACITY;

  logic clk = 1'b0;
  logic rst;
  int   send_idle_pct;
  int   stall_pct;
  int   cycle_count = 0;

  sorted_set_tracker #(CAPACITY) tracker;

  ssen_req_if req ();
  ssen_rsp_if rsp ();

  sorted_set_engine_core #(.CAPACITY(CAPACITY)) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sorted_set_engine_core verification failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    rsp.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      tracker.check_response(rsp.status, rsp.count);
    end
  end

  task automatic send_request(input logic [ssen_pkg::CMD_W-1:0] command,
                              input logic signed [ssen_pkg::KEY_W-1:0] key);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid   <= 1'b1;
    req.command <= command;
    req.key     <= key;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    tracker.note_request(command, key);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    while (tracker.awaited.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [ssen_pkg::KEY_W-1:0] random_key();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 4 && tracker.members.size() != 0) return tracker.pick_member();
    if (pick < 6) return ssen_pkg::KEY_W'($signed($urandom_range(0, 63)) - 32);
    if (pick == 6) begin
      case ($urandom_range(0, 5))
        0: return 32'sh8000_0000;
        1: return 32'sh8000_0001;
        2: return 32'sh7FFF_FFFF;
        3: return 32'sh7FFF_FFFE;
        4: return 32'sh0000_0000;
        default: return -32'sd1;
      endcase
    end
    return $urandom();
  endfunction

  task automatic random_request(input bit filling);
    int unsigned                  roll;
    logic [ssen_pkg::CMD_W-1:0]   command;
    roll = $urandom_range(0, 99);
    if (filling) begin
      if (roll < 75) command = ssen_pkg::CMD_INSERT;
      else if (roll < 85) command = ssen_pkg::CMD_REMOVE;
      else command = ssen_pkg::CMD_FIND;
    end else begin
      if (roll < 36) command = ssen_pkg::CMD_INSERT;
      else if (roll < 70) command = ssen_pkg::CMD_REMOVE;
      else if (roll < 96) command = ssen_pkg::CMD_FIND;
      else command = ssen_pkg::CMD_CLEAR;
    end
    send_request(command, random_key());
  endtask

  initial begin
    rst           = 1'b1;
    req.valid     = 1'b0;
    req.command   = ssen_pkg::CMD_INSERT;
    req.key       = '0;
    rsp.ready     = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    tracker       = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_request(ssen_pkg::CMD_FIND, 32'sd5);
    send_request(ssen_pkg::CMD_REMOVE, 32'sd5);
    send_request(ssen_pkg::CMD_CLEAR, 32'sh7FFF_FFFF);
    send_request(ssen_pkg::CMD_INSERT, 32'sh7FFF_FFFF);
    send_request(ssen_pkg::CMD_INSERT, 32'sh8000_0000);
    send_request(ssen_pkg::CMD_INSERT, 32'sd0);
    send_request(ssen_pkg::CMD_INSERT, -32'sd1);
    send_request(ssen_pkg::CMD_INSERT, 32'sd1);
    send_request(ssen_pkg::CMD_INSERT, 32'sh8000_0000);
    send_request(ssen_pkg::CMD_FIND, 32'sh8000_0000);
    send_request(ssen_pkg::CMD_FIND, 32'sh7FFF_FFFF);
    send_request(ssen_pkg::CMD_FIND, 32'sd7);
    send_request(ssen_pkg::CMD_REMOVE, 32'sd0);
    send_request(ssen_pkg::CMD_REMOVE, 32'sd0);
    send_request(ssen_pkg::CMD_INSERT, 32'sh7FFF_FFFE);
    send_request(ssen_pkg::CMD_INSERT, 32'sh8000_0001);
    send_request(ssen_pkg::CMD_REMOVE, 32'sh7FFF_FFFF);
    send_request(ssen_pkg::CMD_REMOVE, 32'sh8000_0000);
    send_request(ssen_pkg::CMD_FIND, -32'sd1);
    send_request(ssen_pkg::CMD_CLEAR, 32'sd0);
    send_request(ssen_pkg::CMD_FIND, -32'sd1);
    send_request(ssen_pkg::CMD_INSERT, 32'sd5);

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 46;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 46;
        end
        default: begin
          send_idle_pct = 26;
          stall_pct     = 26;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) random_request(phase % 3 == 0);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.failures == 0) begin
      $display("sorted_set_engine_core verification clean");
    end else begin
      $display("sorted_set_engine_core verification failed");
    end
    $finish;
  end
endmodule
